/* sv/assert_macros.svh */
// Assertion macros shared by the solver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication or plain property checked on every clock edge outside reset.
`define TDSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define TDSS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

/* sv/tdss_pkg.sv */
// Shared types, constants and fixed-point helpers of the tridiagonal solver.
`timescale 1ns / 1ps
package tdss_pkg;
	localparam int MAX_ROWS   = 64;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int CNT_W      = $clog2(MAX_ROWS + 1);
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] lower;
		logic signed [31:0] diag;
		logic signed [31:0] upper;
		logic signed [31:0] rhs;
		logic               last;
		logic               drop;
	} row_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_RD, S_MUL1, S_DIV1S, S_DIV1W, S_DIV2S, S_DIV2W, S_CHK,
		S_BRD, S_BMUL, S_BSCL, S_BDS, S_BDW, S_BOUT
	} back_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// Product in Q32.32 back to Q16.16, truncating toward zero.
	function automatic logic signed [31:0] scale_q16(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p >>> 16;
		if (p[63] && (p[15:0] != 16'd0)) t = t + 64'sd1;
		return sat32(t);
	endfunction
endpackage

/* sv/tdss_front.sv */
// Front end: takes rows in, marks rows beyond capacity and queues them.
`timescale 1ns / 1ps
module tdss_front import tdss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	output logic               row_stall,
	input  logic signed [31:0] lower_coef,
	input  logic signed [31:0] diag_coef,
	input  logic signed [31:0] upper_coef,
	input  logic signed [31:0] rhs_value,
	input  logic               last_row,
	input  logic               full,
	output logic               push,
	output row_t               row
);
	logic [CNT_W-1:0] cnt_q;

	assign row_stall = full;
	assign push      = row_valid && !full;
	always_comb begin
		row.lower = lower_coef;
		row.diag  = diag_coef;
		row.upper = upper_coef;
		row.rhs   = rhs_value;
		row.last  = last_row;
		row.drop  = (cnt_q == CNT_W'(MAX_ROWS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (last_row) cnt_q <= '0;
			else if (!row.drop) cnt_q <= cnt_q + CNT_W'(1);
		end
	end
endmodule

/* sv/tdss_fifo.sv */
// Short queue of rows between the front end and the solver core.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tdss_fifo import tdss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  row_t  wdata,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output row_t  rdata
);
	row_t              slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FCNT_W-1:0] fill_q;

	assign full      = (fill_q == FCNT_W'(FIFO_DEPTH));
	assign not_empty = (fill_q != '0);
	assign rdata     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop) rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop) fill_q <= fill_q + FCNT_W'(1);
			else if (pop && !push) fill_q <= fill_q - FCNT_W'(1);
		end
	end

	`TDSS_NEVER(a_no_push_full, push && full, "queue written while full")
	`TDSS_NEVER(a_no_pop_empty, pop && !not_empty, "queue read while empty")
endmodule

/* sv/tdss_div.sv */
// Iterative signed divider, two quotient bits per cycle, saturating result.
`timescale 1ns / 1ps
module tdss_div import tdss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	logic        busy_q, done_q, neg_q, zden_q;
	logic [4:0]  step_q;
	logic [63:0] a_q, a_n;
	logic [31:0] rem_q, rem_n;
	logic [32:0] b_q, r2;
	logic signed [31:0] quot_q, sat_n;

	always_comb begin
		a_n   = a_q;
		rem_n = rem_q;
		for (int k = 0; k < 2; k++) begin
			r2  = {rem_n, a_n[63]};
			a_n = {a_n[62:0], 1'b0};
			if (r2 >= b_q) begin
				r2     = r2 - b_q;
				a_n[0] = 1'b1;
			end
			rem_n = r2[31:0];
		end
		if (zden_q) sat_n = '0;
		else if (neg_q) sat_n = (a_n > 64'h80000000) ? 32'sh80000000 : 32'(-a_n);
		else sat_n = (a_n > 64'h7fffffff) ? 32'sh7fffffff : a_n[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= num[63] ? 64'(-num) : 64'(num);
			b_q    <= den[31] ? 33'(-{den[31], den}) : {1'b0, den};
			rem_q  <= '0;
			neg_q  <= num[63] ^ den[31];
			zden_q <= (den == '0);
		end else if (busy_q) begin
			a_q   <= a_n;
			rem_q <= rem_n;
			if (step_q == 5'd31) quot_q <= sat_n;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

/* sv/tdss_back.sv */
// Solver core: forward elimination into row stores, then back substitution.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tdss_back import tdss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_avail,
	input  row_t               row,
	output logic               row_pop,
	output logic               div_start,
	output logic signed [63:0] div_num,
	output logic signed [31:0] div_den,
	input  logic               div_done,
	input  logic signed [31:0] div_quot,
	output logic               sol_valid,
	input  logic               sol_stall,
	output logic signed [31:0] solution_value,
	output logic [ROW_W-1:0]   row_index,
	output logic               singular,
	output logic               last_result
);
	logic signed [31:0] up_mem  [MAX_ROWS];
	logic signed [31:0] piv_mem [MAX_ROWS];
	logic signed [31:0] rhs_mem [MAX_ROWS];

	back_state_t        state_q, state_n;
	row_t               row_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               zero_q;
	logic [ROW_W-1:0]   addr_q, idx_q, top_q;
	logic signed [31:0] rd_up_q, rd_piv_q, rd_rhs_q, q1_q, next_q;
	logic signed [63:0] prod_s1;
	logic               we;
	logic [ROW_W-1:0]   wa;
	logic signed [31:0] wd_piv, wd_rhs;
	logic               out_free, out_load;
	logic               out_v_q, out_sing_q, out_last_q;
	logic signed [31:0] out_val_q;
	logic [ROW_W-1:0]   out_idx_q;
	logic [ROW_W-1:0]   cnt_m1;

	assign cnt_m1   = ROW_W'(cnt_q - CNT_W'(1));
	assign out_free = !out_v_q || !sol_stall;
	assign wa       = cnt_q[ROW_W-1:0];
	assign div_den  = rd_piv_q;
	assign div_num  = prod_s1;

	always_comb begin
		state_n   = state_q;
		row_pop   = 1'b0;
		we        = 1'b0;
		wd_piv    = row_q.diag;
		wd_rhs    = row_q.rhs;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: if (row_avail) begin
				row_pop = 1'b1;
				state_n = S_LOAD;
			end
			S_LOAD: begin
				if (row_q.drop) state_n = S_CHK;
				else if (cnt_q == '0) begin
					we      = 1'b1;
					state_n = S_CHK;
				end else state_n = S_RD;
			end
			S_RD:    state_n = S_MUL1;
			S_MUL1:  state_n = S_DIV1S;
			S_DIV1S: begin
				div_start = 1'b1;
				state_n   = S_DIV1W;
			end
			S_DIV1W: if (div_done) state_n = S_DIV2S;
			S_DIV2S: begin
				div_start = 1'b1;
				state_n   = S_DIV2W;
			end
			S_DIV2W: if (div_done) begin
				we      = 1'b1;
				wd_piv  = sat32(64'(row_q.diag) - 64'(q1_q));
				wd_rhs  = sat32(64'(row_q.rhs) - 64'(div_quot));
				state_n = S_CHK;
			end
			S_CHK:  state_n = row_q.last ? S_BRD : S_IDLE;
			S_BRD:  state_n = S_BMUL;
			S_BMUL: state_n = S_BSCL;
			S_BSCL: state_n = S_BDS;
			S_BDS: begin
				div_start = 1'b1;
				state_n   = S_BDW;
			end
			S_BDW:  if (div_done) state_n = S_BOUT;
			S_BOUT: if (out_free) begin
				out_load = 1'b1;
				state_n  = (idx_q == '0) ? S_IDLE : S_BRD;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			up_mem[wa]  <= row_q.upper;
			piv_mem[wa] <= wd_piv;
			rhs_mem[wa] <= wd_rhs;
		end
		rd_up_q  <= up_mem[addr_q];
		rd_piv_q <= piv_mem[addr_q];
		rd_rhs_q <= rhs_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (row_pop) row_q <= row;
		if (state_q == S_LOAD) addr_q <= cnt_m1;
		if (state_q == S_MUL1) prod_s1 <= rd_up_q * row_q.lower;
		if (state_q == S_DIV1W && div_done) begin
			q1_q    <= div_quot;
			prod_s1 <= rd_rhs_q * row_q.lower;
		end
		if (state_q == S_CHK) begin
			addr_q <= cnt_m1;
			idx_q  <= cnt_m1;
			top_q  <= cnt_m1;
		end
		if (state_q == S_BMUL) begin
			if (idx_q == top_q) prod_s1 <= 64'(rd_rhs_q) <<< 16;
			else prod_s1 <= rd_up_q * next_q;
		end
		if (state_q == S_BSCL && idx_q != top_q)
			prod_s1 <= 64'(sat32(64'(rd_rhs_q) - 64'(scale_q16(prod_s1)))) <<< 16;
		if (state_q == S_BDW && div_done) next_q <= div_quot;
		if (out_load) begin
			out_val_q  <= zero_q ? 32'sd0 : next_q;
			out_idx_q  <= idx_q;
			out_sing_q <= zero_q;
			out_last_q <= (idx_q == '0);
			if (idx_q != '0) begin
				idx_q  <= idx_q - ROW_W'(1);
				addr_q <= idx_q - ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (we) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (wd_piv == '0) zero_q <= 1'b1;
			end
			if (out_load && idx_q == '0) begin
				cnt_q  <= '0;
				zero_q <= 1'b0;
			end
			if (out_load) out_v_q <= 1'b1;
			else if (!sol_stall) out_v_q <= 1'b0;
		end
	end

	assign sol_valid      = out_v_q;
	assign solution_value = out_val_q;
	assign row_index      = out_idx_q;
	assign singular       = out_sing_q;
	assign last_result    = out_last_q;

	`TDSS_ASSERT(a_last_is_row0, out_v_q |-> (out_last_q == (out_idx_q == '0)),
		"last mark not on row zero")
	`TDSS_ASSERT(a_sing_zero, (out_v_q && out_sing_q) |-> (out_val_q == '0),
		"singular result carries a value")
endmodule

/* sv/tridiagonal_system_solver_unit.sv */
// Top level of the tridiagonal system solver (Thomas algorithm, Q16.16).
`timescale 1ns / 1ps
// Usage: rows of the system are offered on the row channel (row_valid,
// row_stall) one per transfer, with their lower, diagonal, upper and
// right-hand-side coefficients; last_row marks the final row. A short queue
// decouples row intake from the solver core, so rows keep arriving while the
// core works. Each row after the first takes two serial divisions in forward
// elimination, both through the shared divider at two quotient bits a cycle;
// row 0 needs no division.
// After the last row, back substitution gives one solution transfer per row
// on the solution channel (sol_valid, sol_stall), from the highest row down
// to row 0, each after one division through the shared divider.
// Rows beyond 64 are dropped; a dropped row with the last mark still starts
// the solve. A zero pivot flags the whole solution as singular with zero
// values. While sol_stall is high the current solution is held and the core
// waits; rows are still queued until the queue fills. Reset clears the
// queue, the row count and the singular flag; the row stores need no clear.
module tridiagonal_system_solver_unit import tdss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	output logic               row_stall,
	input  logic signed [31:0] lower_coef,
	input  logic signed [31:0] diag_coef,
	input  logic signed [31:0] upper_coef,
	input  logic signed [31:0] rhs_value,
	input  logic               last_row,
	output logic               sol_valid,
	input  logic               sol_stall,
	output logic signed [31:0] solution_value,
	output logic [ROW_W-1:0]   row_index,
	output logic               singular,
	output logic               last_result
);
	row_t               in_row, q_row;
	logic               push, full, pop, not_empty;
	logic               div_start, div_done;
	logic signed [63:0] div_num;
	logic signed [31:0] div_den, div_quot;

	// Intake: classifies each row and pushes it into the queue.
	tdss_front u_front (
		.clk, .arst_n, .row_valid, .row_stall,
		.lower_coef, .diag_coef, .upper_coef, .rhs_value, .last_row,
		.full, .push, .row(in_row)
	);

	tdss_fifo u_fifo (
		.clk, .arst_n, .push, .wdata(in_row), .full,
		.pop, .not_empty, .rdata(q_row)
	);

	// Solver core with its row stores and output register.
	tdss_back u_back (
		.clk, .arst_n, .row_avail(not_empty), .row(q_row), .row_pop(pop),
		.div_start, .div_num, .div_den, .div_done, .div_quot,
		.sol_valid, .sol_stall, .solution_value, .row_index, .singular,
		.last_result
	);

	// One divider serves both elimination and back substitution.
	tdss_div u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);
endmodule

/* verif/tridiagonal_system_solver_unit_test.sv */
// Self-checking testbench of the tridiagonal system solver unit.
`timescale 1ns / 1ps
module tridiagonal_system_solver_unit_test;
	import tdss_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic [ROW_W-1:0]   index;
		logic               sing;
		logic               last;
	} solution_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               row_valid = 1'b0;
	logic               row_stall;
	logic signed [31:0] lower_coef = '0;
	logic signed [31:0] diag_coef = '0;
	logic signed [31:0] upper_coef = '0;
	logic signed [31:0] rhs_value = '0;
	logic               last_row = 1'b0;
	logic               sol_valid;
	logic               sol_stall = 1'b0;
	logic signed [31:0] solution_value;
	logic [ROW_W-1:0]   row_index;
	logic               singular;
	logic               last_result;

	tridiagonal_system_solver_unit dut (.*);

	// Shadow of the elimination state, held in 64-bit variables clamped to the 32-bit range.
	longint    upper_mem [MAX_ROWS];
	longint    pivot_mem [MAX_ROWS];
	longint    frhs_mem [MAX_ROWS];
	int        rows_held = 0;
	bit        zero_pivot = 1'b0;
	solution_t pending_solutions [$];
	int        errors = 0;
	int        solutions_seen = 0;
	int        systems_sent = 0;
	bit        quiet = 1'b0;

	initial forever #5 clk = ~clk;

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Quotient truncated toward zero; a zero divisor gives zero.
	function automatic longint quot32(longint num, longint den);
		if (den == 0) return 0;
		return clamp32(num / den);
	endfunction

	// Forward elimination on one accepted row; back substitution on the last one.
	task automatic eliminate_row(logic signed [31:0] l, logic signed [31:0] d,
			logic signed [31:0] u, logic signed [31:0] r, logic last);
		longint    p, f, nxt, t, x;
		int        i;
		solution_t s;
		if (rows_held < MAX_ROWS) begin
			if (rows_held == 0) begin
				p = d;
				f = r;
			end else begin
				p = clamp32(longint'(d) - quot32(upper_mem[rows_held-1] * l,
					pivot_mem[rows_held-1]));
				f = clamp32(longint'(r) - quot32(frhs_mem[rows_held-1] * l,
					pivot_mem[rows_held-1]));
			end
			upper_mem[rows_held] = u;
			pivot_mem[rows_held] = p;
			frhs_mem[rows_held] = f;
			if (p == 0) zero_pivot = 1'b1;
			rows_held++;
		end
		if (last) begin
			nxt = 0;
			for (i = rows_held - 1; i >= 0; i--) begin
				if (i == rows_held - 1) begin
					x = quot32(frhs_mem[i] * 65536, pivot_mem[i]);
				end else begin
					t = clamp32((upper_mem[i] * nxt) / 65536);
					x = quot32(clamp32(frhs_mem[i] - t) * 65536, pivot_mem[i]);
				end
				nxt = x;
				s.value = zero_pivot ? 32'sd0 : x[31:0];
				s.index = i[ROW_W-1:0];
				s.sing = zero_pivot;
				s.last = (i == 0);
				pending_solutions.push_back(s);
			end
			rows_held = 0;
			zero_pivot = 1'b0;
			systems_sent++;
		end
	endtask

	// Offers one row and holds it until the transfer takes place.
	task automatic send_row(logic signed [31:0] l, logic signed [31:0] d,
			logic signed [31:0] u, logic signed [31:0] r, logic last);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			row_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		row_valid <= 1'b1;
		lower_coef <= l;
		diag_coef <= d;
		upper_coef <= u;
		rhs_value <= r;
		last_row <= last;
		forever begin
			@(posedge clk);
			if (!row_stall) break;
		end
		eliminate_row(l, d, u, r, last);
	endtask

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Receiver side: random stall bursts, none once the run goes quiet.
	initial begin
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if (!quiet) begin
				sol_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				sol_stall <= 1'b0;
			end
		end
	end

	// Every solution transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		solution_t e;
		if (arst_n && sol_valid && !sol_stall) begin
			solutions_seen++;
			if (pending_solutions.size() == 0) begin
				report($sformatf("unexpected solution row %0d", row_index));
			end else begin
				e = pending_solutions.pop_front();
				if (solution_value !== e.value)
					report($sformatf("row %0d value %h, want %h", e.index,
						solution_value, e.value));
				if (row_index !== e.index)
					report($sformatf("row index %0d, want %0d", row_index, e.index));
				if (singular !== e.sing)
					report($sformatf("row %0d singular %b, want %b", e.index,
						singular, e.sing));
				if (last_result !== e.last)
					report($sformatf("row %0d last %b, want %b", e.index,
						last_result, e.last));
			end
		end
	end

	function automatic logic signed [31:0] rand_diag();
		logic signed [31:0] v;
		v = {16'($urandom_range(2, 60)), 16'($urandom)};
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic logic signed [31:0] rand_small();
		return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
	endfunction

	task automatic wait_drained();
		while (pending_solutions.size() != 0) @(posedge clk);
	endtask

	// Extremes, single row, zero pivot and the symmetric case.
	task automatic test_directed();
		send_row(32'sh12345678, 32'sh00020000, 32'sh7fffffff, 32'sh00050000, 1'b1);
		send_row(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
		send_row(32'sh80000000, 32'sh80000000, 0, 32'sh80000000, 1'b1);
		send_row(0, 32'sh00000001, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_row(32'sh7fffffff, 32'sh00000001, 32'sh00010000, 32'sh7fffffff, 1'b1);
		send_row(0, 0, 32'sh00010000, 32'sh00010000, 1'b0);
		send_row(32'sh00010000, 32'sh00030000, 32'sh00010000, 32'sh00020000, 1'b0);
		send_row(32'sh00010000, 32'sh00030000, 0, 32'sh00010000, 1'b1);
		send_row(0, 32'sh00040000, 32'shffff0000, 32'sh00010000, 1'b0);
		send_row(32'shffff0000, 32'sh00040000, 32'sh00018000, 32'sh00020000, 1'b0);
		send_row(32'sh00018000, 32'sh00040000, 32'shdeadbeef, 32'shffff8000, 1'b1);
		send_row(0, 0, 0, 0, 1'b1);
		send_row(0, 32'shffffffff, 32'sh00000001, 32'sh00000001, 1'b1);
	endtask

	// A system of more rows than are held: surplus rows, last one included, drop.
	task automatic test_row_limit();
		int i;
		for (i = 0; i < MAX_ROWS + 2; i++)
			send_row(rand_small(), rand_diag(), rand_small(), rand_small(),
				i == MAX_ROWS + 1);
	endtask

	// Short systems with random content; some full-range and some symmetric.
	task automatic test_random_systems(int rows_wanted);
		int                 n, i, sent;
		bit                 wild, symm;
		logic signed [31:0] prev_u, l, d, u, r;
		sent = 0;
		while (sent < rows_wanted) begin
			n = $urandom_range(1, 6);
			wild = ($urandom_range(0, 4) == 0);
			symm = ($urandom_range(0, 2) == 0);
			prev_u = 0;
			for (i = 0; i < n; i++) begin
				if (wild) begin
					l = $urandom; d = $urandom; u = $urandom; r = $urandom;
				end else begin
					l = rand_small(); d = rand_diag(); u = rand_small();
					r = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)} + rand_small();
				end
				if (symm) l = prev_u;
				if ($urandom_range(0, 29) == 0) d = 0;
				prev_u = u;
				send_row(l, d, u, r, i == n - 1);
			end
			sent += n;
		end
	endtask

	// The sender holds off until every solution of the previous system is out.
	task automatic test_drain_pause();
		test_random_systems(4);
		row_valid <= 1'b0;
		wait_drained();
		test_random_systems(4);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_row_limit();
		test_random_systems(20);
		test_drain_pause();
		quiet = 1'b1;
		test_random_systems(15);
		row_valid <= 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d systems and %0d solution transfers, including singular,",
			systems_sent, solutions_seen);
		$display("single-row, oversized, symmetric and full-range systems");
		if (errors == 0 && pending_solutions.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
